// ===== rtl/core/base32_to_base64_transcoder_assert.svh =====
// Assertion macros shared by the transcoder RTL.
// Each macro expects clk and rst_n in scope.
`ifndef BASE32_TO_BASE64_TRANSCODER_ASSERT_SVH
`define BASE32_TO_BASE64_TRANSCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define B2B_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define B2B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/b2b_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared types, constants and character mapping for the Base32 to Base64
// transcoder.
// ----------------------------------------------------------------------------
package b2b_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_TWO   = 8'h32;  // '2'
  localparam logic [7:0] CHAR_SEVEN = 8'h37;  // '7'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

  localparam logic [4:0] B32_DIGIT_BASE = 5'd26;  // value of '2'

  // Most output characters one input character can produce
  localparam int MAX_OUT = 4;
  localparam int CNT_W   = 3;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One job: the output characters caused by one input character
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] chars;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Base32 character to 5-bit value; anything outside the alphabet is zero
  function automatic logic [4:0] b32_value(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) begin
      d = ch - CHAR_UC_A;
    end else if (ch >= CHAR_TWO && ch <= CHAR_SEVEN) begin
      d = 8'(B32_DIGIT_BASE) + (ch - CHAR_TWO);
    end
    return d[4:0];
  endfunction

  // 6-bit value to Base64 ASCII
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CHAR_UC_A + 8'(v);
    end else if (v < 6'd52) begin
      c = CHAR_LC_A + 8'(v - 6'd26);
    end else if (v < 6'd62) begin
      c = CHAR_ZERO + 8'(v - 6'd52);
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/base32_to_base64_transcoder.sv =====
`timescale 1ns / 1ps
// Base32 in, Base64 out. One character is taken per cycle as long as the
// four-entry job queue has room; each becomes zero to four output
// characters, and the output side delivers one character per cycle while
// out_stall is low (an input yields 1 or 0 characters most of the time, up
// to 4 on the last character with its '=' padding). The output register
// limits the sustained rate. A job is registered in the queue, then its
// characters in the output register. in_is_last ends a string and returns
// the block to its start state; out_last marks a string's final character.
// ----------------------------------------------------------------------------
// base32_to_base64_transcoder
// Top level: front stream tracker, job queue and output serializer.
// ----------------------------------------------------------------------------
`include "base32_to_base64_transcoder_assert.svh"

module base32_to_base64_transcoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic               q_push;
  logic               q_pop;
  b2b_pkg::job_t      q_push_job;
  b2b_pkg::job_t      q_head;
  b2b_pkg::q_status_t q_status;

  // Front: accept and map characters
  b2b_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .in_is_last (in_is_last),
    .q_status   (q_status),
    .push       (q_push),
    .push_job   (q_push_job)
  );

  // Job queue
  b2b_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  // Back: serialize jobs
  b2b_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_status  (q_status),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  // Checks
  `B2B_ASSERT_NOW(a_no_overflow, q_push, !q_status.full, "job pushed into full queue")
  `B2B_ASSERT_NOW(a_no_underflow, q_pop, !q_status.empty, "job popped from empty queue")
  `B2B_ASSERT_NOW(a_job_nonempty, q_push, q_push_job.count != 3'd0, "empty job queued")
  `B2B_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "stalled request dropped")

endmodule

// ===== rtl/core/b2b_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2b_front
// Accepts Base32 characters, tracks the bit stream and turns each request
// into a job of up to four Base64 characters for the queue.
// ----------------------------------------------------------------------------
module b2b_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char,
  input  logic                in_is_last,
  input  b2b_pkg::q_status_t  q_status,
  output logic                push,
  output b2b_pkg::job_t       push_job
);

  logic [11:0] buf_r,   buf_nxt;
  logic [3:0]  cnt_r,   cnt_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  mod_r,   mod_nxt;
  logic        stop_r,  stop_nxt;
  logic        accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Bit stream step: add five bits, peel off whole sextets, flush on last
  always_comb begin
    logic [16:0] acc;
    logic [4:0]  cnt;
    logic [2:0]  ph;
    logic [4:0]  whole;
    logic [5:0]  v;
    logic [2:0]  n;
    logic [1:0]  md;
    logic        stp;
    b2b_pkg::job_t job;

    acc   = {5'b0, buf_r};
    cnt   = {1'b0, cnt_r};
    ph    = phase_r;
    md    = mod_r;
    stp   = stop_r;
    n     = '0;
    job   = '0;
    whole = '0;
    v     = '0;

    if (!stp) begin
      if (in_char == b2b_pkg::CHAR_PAD) begin
        stp = 1'b1;
      end else begin
        acc = {acc[11:0], b2b_pkg::b32_value(in_char)};
        cnt = cnt + 5'd5;
        ph  = ph + 3'd5;
        // at most two sextets complete per character
        for (int k = 0; k < 2; k++) begin
          if ((cnt - {2'b0, ph}) >= 5'd6) begin
            v = 6'(acc >> (cnt - 5'd6));
            job.chars[n[1:0]] = b2b_pkg::b64_char(v);
            n   = n + 3'd1;
            md  = md + 2'd1;
            cnt = cnt - 5'd6;
            acc = acc & ((17'd1 << cnt) - 17'd1);
          end
        end
      end
    end

    if (in_is_last) begin
      // leftover bits of whole bytes, zero-padded to a sextet
      whole = cnt - {2'b0, ph};
      if (whole != 5'd0) begin
        v = 6'((acc >> ph) << (5'd6 - whole));
        job.chars[n[1:0]] = b2b_pkg::b64_char(v);
        n  = n + 3'd1;
        md = md + 2'd1;
      end
      // pad to a multiple of four
      for (int k = 0; k < 3; k++) begin
        if (md != 2'd0) begin
          job.chars[n[1:0]] = b2b_pkg::CHAR_PAD;
          n  = n + 3'd1;
          md = md + 2'd1;
        end
      end
      buf_nxt   = '0;
      cnt_nxt   = '0;
      phase_nxt = '0;
      mod_nxt   = '0;
      stop_nxt  = 1'b0;
    end else begin
      buf_nxt   = 12'(acc & ((17'd1 << cnt) - 17'd1));
      cnt_nxt   = cnt[3:0];
      phase_nxt = ph;
      mod_nxt   = md;
      stop_nxt  = stp;
    end

    job.count = n;
    job.last  = in_is_last;
    push_job  = job;
  end

  assign push = accept && (push_job.count != '0);

  // Stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      cnt_r   <= '0;
      phase_r <= '0;
      mod_r   <= '0;
      stop_r  <= 1'b0;
    end else if (accept) begin
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      mod_r   <= mod_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

// ===== rtl/core/b2b_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2b_queue
// Small job FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module b2b_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b2b_pkg::job_t       push_job,
  input  logic                pop,
  output b2b_pkg::job_t       head,
  output b2b_pkg::q_status_t  status
);

  b2b_pkg::job_t                 mem_r [b2b_pkg::QUEUE_DEPTH];
  logic [b2b_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [b2b_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [b2b_pkg::QPTR_W:0]      fill_r,   fill_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.empty = (fill_r == '0);
  assign status.full  = (fill_r == (b2b_pkg::QPTR_W+1)'(b2b_pkg::QUEUE_DEPTH));

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (b2b_pkg::QPTR_W+1)'(push) - (b2b_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/b2b_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2b_back
// Walks through the head job one character per cycle, while out_stall is
// low, into the output register.
// ----------------------------------------------------------------------------
module b2b_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b2b_pkg::job_t       head,
  input  b2b_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char,
  output logic                out_last
);

  logic [1:0] idx_r,   idx_nxt;
  logic       vld_r,   vld_nxt;
  logic [7:0] char_r,  char_nxt;
  logic       last_r,  last_nxt;
  logic       load;
  logic       at_end;

  // Output register free this cycle and a job is waiting
  assign load   = (!vld_r || !out_stall) && !q_status.empty;
  assign at_end = ({1'b0, idx_r} == (head.count - 3'd1));
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r && out_stall;
    char_nxt = char_r;
    last_nxt = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      char_nxt = head.chars[idx_r];
      last_nxt = head.last && at_end;
      idx_nxt  = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = vld_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule
